### hw/rtl/assert_macros.svh
// assertion helpers, clocked on clk_i and quiet while rst_ni is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

`define ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

### hw/rtl/hbf_pkg.sv
`default_nettype none

package hbf_pkg;

  typedef enum logic [1:0] {
    ACT_START   = 2'd0,
    ACT_PAYLOAD = 2'd1,
    ACT_END     = 2'd2,
    ACT_RSVD    = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    CRC_8  = 2'd0,
    CRC_10 = 2'd1,
    CRC_16 = 2'd2,
    CRC_32 = 2'd3
  } crc_sel_e;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_FLAG_O,
    PH_HDR,
    PH_PAY,
    PH_CRC,
    PH_FLAG_C,
    PH_PAD
  } phase_e;

  typedef struct packed {
    action_e    action;
    logic [3:0] frame_type;
    logic [3:0] address;
    logic [3:0] index;
    logic       data_bit;
  } in_t;

  typedef struct packed {
    logic out_bit;
    logic last_of_run;
  } out_t;

  typedef struct packed {
    logic clr;
    logic feed;
    logic data_bit;
  } crc_ctl_t;

  typedef struct packed {
    logic       busy;
    logic       stuff;
    logic [2:0] ones;
  } seq_status_t;

  localparam int CrcMaxW  = 32;
  localparam int CntW     = 5;
  localparam int CfgAddrW = 3;
  localparam int CfgDataW = 32;

  localparam logic [7:0] Flag      = 8'b0111_1110;
  localparam logic [2:0] FlagLast  = 3'd7;
  localparam logic [3:0] HdrLast   = 4'd11;
  localparam logic [2:0] StuffPrev = 3'd4;
  localparam logic [2:0] StuffRun  = 3'd5;

  localparam logic [0:0] RegCrcWidthSel = 1'b0;

  function automatic logic [5:0] crc_width(input crc_sel_e sel);
    logic [5:0] w;
    case (sel)
      CRC_8:   w = 6'd8;
      CRC_10:  w = 6'd10;
      CRC_16:  w = 6'd16;
      CRC_32:  w = 6'd32;
      default: w = 6'd8;
    endcase
    return w;
  endfunction

  function automatic logic [CrcMaxW-1:0] crc_poly(input crc_sel_e sel);
    logic [CrcMaxW-1:0] p;
    case (sel)
      CRC_8:   p = 32'h0000_0007;
      CRC_10:  p = 32'h0000_0235;
      CRC_16:  p = 32'h0000_1021;
      CRC_32:  p = 32'h04C1_1DB7;
      default: p = 32'h0000_0007;
    endcase
    return p;
  endfunction

  // one step of the serial division register
  function automatic logic [CrcMaxW-1:0] crc_step(input logic [CrcMaxW-1:0] rem,
                                                  input logic b, input crc_sel_e sel);
    logic [5:0]         w;
    logic [CrcMaxW-1:0] mask;
    logic [CrcMaxW-1:0] r;
    logic               fb;
    w    = crc_width(sel);
    // shifting out all 32 bits wraps to zero, so the full width gets all ones
    mask = (CrcMaxW'(1) << w) - CrcMaxW'(1);
    fb   = rem[CntW'(w - 6'd1)] ^ b;
    r    = (rem << 1) & mask;
    if (fb) begin
      r = r ^ crc_poly(sel);
    end
    return r & mask;
  endfunction

endpackage

`default_nettype wire

### hw/rtl/hbf_crc.sv
`default_nettype none

module hbf_crc (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  input  hbf_pkg::crc_sel_e              sel_i,
  input  hbf_pkg::crc_ctl_t              ctl_i,
  output logic [hbf_pkg::CrcMaxW-1:0]    rem_o
);

  logic [hbf_pkg::CrcMaxW-1:0] rem_q, rem_d;

  always_comb begin
    rem_d = rem_q;
    if (ctl_i.clr) begin
      rem_d = '0;
    end else if (ctl_i.feed) begin
      rem_d = hbf_pkg::crc_step(rem_q, ctl_i.data_bit, sel_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q <= '0;
    end else begin
      rem_q <= rem_d;
    end
  end

  assign rem_o = rem_q;

endmodule

`default_nettype wire

### hw/rtl/hbf_seq.sv
`default_nettype none

module hbf_seq (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  input  hbf_pkg::crc_sel_e              sel_i,
  input  wire                            item_valid_i,
  input  hbf_pkg::in_t                   item_i,
  output logic                           item_take_o,
  input  wire                            adv_i,
  input  wire [hbf_pkg::CrcMaxW-1:0]     crc_i,
  output hbf_pkg::crc_ctl_t              crc_ctl_o,
  output logic                           emit_valid_o,
  output hbf_pkg::out_t                  emit_o,
  output hbf_pkg::seq_status_t           status_o
);

  hbf_pkg::phase_e             phase_q, phase_d;
  logic [hbf_pkg::CntW-1:0]    cnt_q, cnt_d;
  logic                        stuff_q, stuff_d;
  logic [2:0]                  ones_q, ones_d;
  logic [1:0]                  cnt4_q, cnt4_d;
  logic                        in_frame_q, in_frame_d;
  logic [11:0]                 hdr_q, hdr_d;
  logic                        pay_q, pay_d;

  logic [5:0]                  w;
  logic [hbf_pkg::CntW-1:0]    wlast;
  logic                        b;
  logic                        stuffable;
  logic                        feed;
  logic                        advance;
  logic                        done;
  logic                        close;

  always_comb begin
    phase_d      = phase_q;
    cnt_d        = cnt_q;
    stuff_d      = stuff_q;
    ones_d       = ones_q;
    cnt4_d       = cnt4_q;
    in_frame_d   = in_frame_q;
    hdr_d        = hdr_q;
    pay_d        = pay_q;
    crc_ctl_o    = '0;
    emit_valid_o = 1'b0;
    emit_o       = '0;
    item_take_o  = 1'b0;
    w            = hbf_pkg::crc_width(sel_i);
    wlast        = hbf_pkg::CntW'(w - 6'd1);
    b            = 1'b0;
    stuffable    = 1'b0;
    feed         = 1'b0;
    advance      = 1'b0;
    done         = 1'b0;
    close        = 1'b0;

    if (phase_q != hbf_pkg::PH_IDLE && adv_i) begin
      emit_valid_o = 1'b1;
      cnt4_d       = cnt4_q + 2'd1;
      if (stuff_q) begin
        // inserted zero after five ones, then resume where the data bit left off
        stuff_d = 1'b0;
        ones_d  = '0;
        advance = 1'b1;
      end else begin
        case (phase_q)
          hbf_pkg::PH_FLAG_O, hbf_pkg::PH_FLAG_C: begin
            b       = hbf_pkg::Flag[cnt_q[2:0]];
            advance = 1'b1;
          end
          hbf_pkg::PH_PAD: begin
            advance = 1'b1;
          end
          hbf_pkg::PH_HDR: begin
            b         = hdr_q[hbf_pkg::HdrLast - cnt_q[3:0]];
            stuffable = 1'b1;
            feed      = 1'b1;
          end
          hbf_pkg::PH_PAY: begin
            b         = pay_q;
            stuffable = 1'b1;
            feed      = 1'b1;
          end
          hbf_pkg::PH_CRC: begin
            b         = crc_i[wlast - cnt_q];
            stuffable = 1'b1;
          end
          default: begin
            advance = 1'b1;
          end
        endcase
        if (stuffable) begin
          crc_ctl_o.feed     = feed;
          crc_ctl_o.data_bit = b;
          if (b) begin
            ones_d = ones_q + 3'd1;
            if (ones_q == hbf_pkg::StuffPrev) begin
              stuff_d = 1'b1;
            end else begin
              advance = 1'b1;
            end
          end else begin
            ones_d  = '0;
            advance = 1'b1;
          end
        end
      end

      if (advance) begin
        case (phase_q)
          hbf_pkg::PH_FLAG_O: begin
            if (cnt_q[2:0] == hbf_pkg::FlagLast) begin
              phase_d = hbf_pkg::PH_HDR;
              cnt_d   = '0;
            end else begin
              cnt_d = cnt_q + 5'd1;
            end
          end
          hbf_pkg::PH_HDR: begin
            if (cnt_q[3:0] == hbf_pkg::HdrLast) begin
              done = 1'b1;
            end else begin
              cnt_d = cnt_q + 5'd1;
            end
          end
          hbf_pkg::PH_PAY: begin
            done = 1'b1;
          end
          hbf_pkg::PH_CRC: begin
            if (cnt_q == wlast) begin
              phase_d = hbf_pkg::PH_FLAG_C;
              cnt_d   = '0;
            end else begin
              cnt_d = cnt_q + 5'd1;
            end
          end
          hbf_pkg::PH_FLAG_C: begin
            if (cnt_q[2:0] == hbf_pkg::FlagLast) begin
              if (cnt4_d == 2'd0) begin
                done  = 1'b1;
                close = 1'b1;
              end else begin
                phase_d = hbf_pkg::PH_PAD;
              end
            end else begin
              cnt_d = cnt_q + 5'd1;
            end
          end
          hbf_pkg::PH_PAD: begin
            if (cnt4_d == 2'd0) begin
              done  = 1'b1;
              close = 1'b1;
            end
          end
          default: begin
            done = 1'b1;
          end
        endcase
      end

      if (done) begin
        phase_d = hbf_pkg::PH_IDLE;
      end
      if (close) begin
        crc_ctl_o.clr = 1'b1;
        ones_d        = '0;
        cnt4_d        = '0;
        in_frame_d    = 1'b0;
      end
      emit_o.out_bit     = b;
      emit_o.last_of_run = done;
    end

    // next word loads while the last bit of the current one goes out
    if (item_valid_i && (phase_q == hbf_pkg::PH_IDLE || done)) begin
      item_take_o = 1'b1;
      case (item_i.action)
        hbf_pkg::ACT_START: begin
          phase_d       = hbf_pkg::PH_FLAG_O;
          cnt_d         = '0;
          hdr_d         = {item_i.frame_type, item_i.address, item_i.index};
          crc_ctl_o.clr = 1'b1;
          stuff_d       = 1'b0;
          ones_d        = '0;
          cnt4_d        = '0;
          in_frame_d    = 1'b1;
        end
        hbf_pkg::ACT_PAYLOAD: begin
          if (in_frame_d) begin
            phase_d = hbf_pkg::PH_PAY;
            pay_d   = item_i.data_bit;
          end
        end
        hbf_pkg::ACT_END: begin
          if (in_frame_d) begin
            phase_d = hbf_pkg::PH_CRC;
            cnt_d   = '0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= hbf_pkg::PH_IDLE;
      cnt_q      <= '0;
      stuff_q    <= 1'b0;
      ones_q     <= '0;
      cnt4_q     <= '0;
      in_frame_q <= 1'b0;
    end else begin
      phase_q    <= phase_d;
      cnt_q      <= cnt_d;
      stuff_q    <= stuff_d;
      ones_q     <= ones_d;
      cnt4_q     <= cnt4_d;
      in_frame_q <= in_frame_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hdr_q <= hdr_d;
    pay_q <= pay_d;
  end

  assign status_o.busy  = (phase_q != hbf_pkg::PH_IDLE);
  assign status_o.stuff = stuff_q;
  assign status_o.ones  = ones_q;

endmodule

`default_nettype wire

### hw/rtl/hdlc_style_bit_framer_crc.sv
// bit framer with bit stuffing and crc, one line bit per output word
// input channel: in_valid_i/in_ready_o with an in_t word (start, payload bit,
// end); output channel: out_valid_o/out_ready_i with an out_t word holding one
// line bit and a flag on the last bit produced by that input word
// apb port: register crc_width_select at byte address 0 (8/10/16/32 bit crc)
// the first bit of a word leaves through the input register, then the bit
// sequencer's state, then the output register
// throughput: one line bit per cycle while out_ready_i does not stall, set by
// the single-bit sequencer; a payload word makes one line bit (two with a
// stuffed zero), a start word 20 to 22, an end word crc width + 8 + stuffed
// zeros + padding, at most 50; words that make no bits (unused action,
// payload or end outside a frame) are dropped when the sequencer takes them
// the next word is taken while a finished bit still waits in the output register
// reset: no frame open, crc and counters cleared, crc width select 8 bits
// a stall on out_ready_i freezes a busy sequencer; one more input word is held
`default_nettype none

module hdlc_style_bit_framer_crc (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  input  wire                               in_valid_i,
  output logic                              in_ready_o,
  input  hbf_pkg::in_t                      in_data_i,
  output logic                              out_valid_o,
  input  wire                               out_ready_i,
  output hbf_pkg::out_t                     out_data_o,
  input  wire                               psel,
  input  wire                               penable,
  input  wire                               pwrite,
  input  wire [hbf_pkg::CfgAddrW-1:0]       paddr,
  input  wire [hbf_pkg::CfgDataW-1:0]       pwdata,
  output logic [hbf_pkg::CfgDataW-1:0]      prdata,
  output logic                              pready
);

  `include "assert_macros.svh"

  hbf_pkg::crc_sel_e            sel_q;
  logic                         hold_v_q;
  hbf_pkg::in_t                 hold_q;
  logic                         out_v_q;
  hbf_pkg::out_t                out_q;

  logic                         take;
  logic                         adv;
  logic                         in_acc;
  logic                         reg_hit;
  logic                         emit_valid;
  hbf_pkg::out_t                emit;
  hbf_pkg::crc_ctl_t            crc_ctl;
  hbf_pkg::seq_status_t         seq_st;
  logic [hbf_pkg::CrcMaxW-1:0]  crc_rem;

  assign adv        = !out_v_q || out_ready_i;
  assign in_ready_o = !hold_v_q || take;
  assign in_acc     = in_valid_i && in_ready_o;

  // config port
  assign pready  = 1'b1;
  assign reg_hit = (paddr[hbf_pkg::CfgAddrW-1:2] == hbf_pkg::RegCrcWidthSel);
  assign prdata  = reg_hit ? hbf_pkg::CfgDataW'(sel_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sel_q <= hbf_pkg::CRC_8;
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      sel_q <= hbf_pkg::crc_sel_e'(pwdata[1:0]);
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_v_q <= 1'b0;
    end else if (in_acc) begin
      hold_v_q <= 1'b1;
    end else if (take) begin
      hold_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      hold_q <= in_data_i;
    end
  end

  hbf_crc u_crc (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .sel_i  (sel_q),
    .ctl_i  (crc_ctl),
    .rem_o  (crc_rem)
  );

  hbf_seq u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .sel_i        (sel_q),
    .item_valid_i (hold_v_q),
    .item_i       (hold_q),
    .item_take_o  (take),
    .adv_i        (adv),
    .crc_i        (crc_rem),
    .crc_ctl_o    (crc_ctl),
    .emit_valid_o (emit_valid),
    .emit_o       (emit),
    .status_o     (seq_st)
  );

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (adv) begin
      out_v_q <= emit_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && emit_valid) begin
      out_q <= emit;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

  `ASSERT_CLK(a_ready_room, !in_ready_o |-> hold_v_q, "input stalled with an empty holding register")
  `ASSERT_NEVER(a_stuff_idle, seq_st.stuff && !seq_st.busy, "stuffed zero pending while idle")
  `ASSERT_CLK(a_ones_bound, !seq_st.stuff |-> (seq_st.ones < hbf_pkg::StuffRun), "ones run too long")
  `ASSERT_CLK(a_last_frees, (emit_valid && emit.last_of_run && !hold_v_q) |=> !seq_st.busy, "sequencer busy after last bit")

endmodule

`default_nettype wire
